// ----- rtl/core/rsi_pkg.sv -----
package rsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int UNIT_BITS = 28;
  localparam int SQ_W      = 72;
  localparam int RT_W      = 36;
  localparam int DV_W      = 64;
  localparam int QT_W      = UNIT_BITS + 1;
  localparam int LEN_BITS  = 34;
  localparam int HALF_BITS = 31;
  localparam int NQ_BITS   = UNIT_BITS + 1;
  localparam int NRM_BITS  = FRAC_BITS + 1;
  localparam int BACK_SH   = UNIT_BITS - FRAC_BITS;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } reg_e;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [RT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [DV_W-1:0] rem;
    logic [QT_W-1:0] quo;
  } dv_t;

  // one result bit of a floor square root, remainder form
  function automatic sq_t sqrt_step(sq_t s, int b);
    sq_t r;
    logic [SQ_W-1:0] trial;
    r = s;
    trial = ({{(SQ_W-RT_W){1'b0}}, s.root} << (b + 1))
          + ({{(SQ_W-1){1'b0}}, 1'b1} << (2 * b));
    if (s.rem >= trial) begin
      r.rem     = s.rem - trial;
      r.root[b] = 1'b1;
    end
    return r;
  endfunction

  // one quotient bit of a restoring divide
  function automatic dv_t div_step(dv_t s, logic [LEN_BITS-1:0] den, int j);
    dv_t r;
    logic [DV_W-1:0] sub;
    r = s;
    sub = {{(DV_W-LEN_BITS){1'b0}}, den} << j;
    if (s.rem >= sub) begin
      r.rem    = s.rem - sub;
      r.quo[j] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [31:0] mag33(logic signed [32:0] v);
    logic [32:0] a;
    a = v[32] ? 33'(-v) : 33'(v);
    return a[31:0];
  endfunction

  function automatic logic [31:0] sat32(logic signed [37:0] v);
    logic [31:0] r;
    if (v > 38'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -38'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/ray_sphere_intersect.sv -----
// Ray / sphere intersection, signed Q16.16, fully pipelined.
// Throughput: one ray per cycle while the output is not stalled.
// The square roots and divides are unrolled one bit per stage.
// A stall on the output freezes the whole pipe.
// Reset clears the valid bits; the centre resets to 0 and the radius to 1.0.
module ray_sphere_intersect
  import rsi_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [191:0] s_axis_tdata_i,
  // operation
  input  logic [0:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // point_x/y/z, normal_x/y/z, back_x/y/z
  output logic [287:0] m_axis_tdata_o,
  // hit
  output logic [0:0]   m_axis_tuser_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int SA0   = 3;
  localparam int DB0   = SA0 + LEN_BITS;
  localparam int P10   = DB0 + NQ_BITS;
  localparam int SH0   = P10 + 6;
  localparam int T10   = SH0 + HALF_BITS;
  localparam int SV0   = T10 + 6;
  localparam int DN0   = SV0 + LEN_BITS;
  localparam int DEPTH = DN0 + NRM_BITS + 1;

  typedef struct packed {
    logic [2:0][31:0] o;
    logic [2:0][32:0] d;
    logic [2:0][32:0] w;
    logic [65:0]      sw;
  } pa_t;

  typedef struct packed {
    logic [2:0][31:0] o;
    logic [2:0]       dneg;
    logic [2:0][32:0] w;
    logic [65:0]      sw;
    logic [LEN_BITS-1:0] len;
  } pb_t;

  typedef struct packed {
    logic [2:0][31:0]        o;
    logic [2:0]              dneg;
    logic [2:0][QT_W-1:0]    nq;
    logic [2:0][31:0]        bk;
    logic [65:0]             sw;
    logic                    lzero;
  } pc_t;

  typedef struct packed {
    pc_t         pc;
    logic [35:0] tc;
    logic        lt;
    logic        eq;
  } pd_t;

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0][31:0] bk;
    logic [2:0][32:0] v;
    logic             hit;
    logic             tang;
  } pe_t;

  typedef struct packed {
    pe_t                 pe;
    logic [LEN_BITS-1:0] vl;
  } pf_t;

  logic        [31:0] ctr_q [3];
  logic        [30:0] rad_q;
  logic               en;
  logic [DEPTH-1:0]   vld_q;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q[0] <= '0;
      ctr_q[1] <= '0;
      ctr_q[2] <= '0;
      rad_q    <= 31'(1 << FRAC_BITS);
    end else if (psel && penable && pwrite) begin
      unique case (reg_e'(paddr[3:2]))
        REG_CENTER_X: ctr_q[0] <= pwdata;
        REG_CENTER_Y: ctr_q[1] <= pwdata;
        REG_CENTER_Z: ctr_q[2] <= pwdata;
        REG_RADIUS:   rad_q    <= pwdata[30:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[3:2]))
      REG_CENTER_X: prdata = ctr_q[0];
      REG_CENTER_Y: prdata = ctr_q[1];
      REG_CENTER_Z: prdata = ctr_q[2];
      REG_RADIUS:   prdata = {1'b0, rad_q};
    endcase
  end

  // flow control
  assign en              = !vld_q[DEPTH-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid_i};
    end
  end

  // stage 0: capture, direction and offset from centre
  pa_t s0_q, s1_q, s2_q;
  logic [2:0][63:0] dsq1_q, wsq1_q;
  logic [65:0]      sd2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s0_q.o[i] <= s_axis_tdata_i[32*i +: 32];
        s0_q.w[i] <= 33'($signed({s_axis_tdata_i[32*i+31], s_axis_tdata_i[32*i +: 32]})
                     - $signed({ctr_q[i][31], ctr_q[i]}));
        if (s_axis_tuser_i[0]) begin
          s0_q.d[i] <= 33'($signed({ctr_q[i][31], ctr_q[i]})
                       - $signed({s_axis_tdata_i[32*i+31], s_axis_tdata_i[32*i +: 32]}));
        end else begin
          s0_q.d[i] <= {s_axis_tdata_i[96+32*i+31], s_axis_tdata_i[96+32*i +: 32]};
        end
      end
      s0_q.sw <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dsq1_q[i] <= 64'(mag33(s0_q.d[i])) * 64'(mag33(s0_q.d[i]));
        wsq1_q[i] <= 64'(mag33(s0_q.w[i])) * 64'(mag33(s0_q.w[i]));
      end
      s1_q <= s0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd2_q    <= 66'(dsq1_q[0]) + 66'(dsq1_q[1]) + 66'(dsq1_q[2]);
      s2_q.o   <= s1_q.o;
      s2_q.d   <= s1_q.d;
      s2_q.w   <= s1_q.w;
      s2_q.sw  <= 66'(wsq1_q[0]) + 66'(wsq1_q[1]) + 66'(wsq1_q[2]);
    end
  end

  // length of the direction
  sq_t sa_q [LEN_BITS];
  pa_t pa_q [LEN_BITS];

  for (genvar k = 0; k < LEN_BITS; k++) begin : g_sqrt_len
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en) begin
          sa_q[k] <= sqrt_step('{rem: SQ_W'(sd2_q), root: '0}, LEN_BITS - 1 - k);
          pa_q[k] <= s2_q;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en) begin
          sa_q[k] <= sqrt_step(sa_q[k-1], LEN_BITS - 1 - k);
          pa_q[k] <= pa_q[k-1];
        end
      end
    end
  end

  // unit direction, three divide lanes
  dv_t db_q [NQ_BITS][3];
  pb_t pb_q [NQ_BITS];
  pb_t pb_d;

  always_comb begin
    pb_d.o   = pa_q[LEN_BITS-1].o;
    pb_d.w   = pa_q[LEN_BITS-1].w;
    pb_d.sw  = pa_q[LEN_BITS-1].sw;
    pb_d.len = sa_q[LEN_BITS-1].root[LEN_BITS-1:0];
    for (int i = 0; i < 3; i++) begin
      pb_d.dneg[i] = pa_q[LEN_BITS-1].d[i][32];
    end
  end

  for (genvar k = 0; k < NQ_BITS; k++) begin : g_div_dir
    for (genvar i = 0; i < 3; i++) begin : g_lane
      if (k == 0) begin : g_first
        always_ff @(posedge clk_i) begin
          if (en) begin
            db_q[k][i] <= div_step('{rem: DV_W'(mag33(pa_q[LEN_BITS-1].d[i])) << UNIT_BITS,
                                     quo: '0}, pb_d.len, NQ_BITS - 1 - k);
          end
        end
      end else begin : g_next
        always_ff @(posedge clk_i) begin
          if (en) begin
            db_q[k][i] <= div_step(db_q[k-1][i], pb_q[k-1].len, NQ_BITS - 1 - k);
          end
        end
      end
    end
    if (k == 0) begin : g_pl_first
      always_ff @(posedge clk_i) begin
        if (en) begin
          pb_q[k] <= pb_d;
        end
      end
    end else begin : g_pl_next
      always_ff @(posedge clk_i) begin
        if (en) begin
          pb_q[k] <= pb_q[k-1];
        end
      end
    end
  end

  // projection onto the ray and closest approach
  pc_t                    pc1_q, pc2_q, pc3_q, pc4_q, pc5_q;
  logic signed [62:0]     prod1_q [3];
  logic signed [64:0]     proj2_q;
  logic signed [35:0]     tc3_q, tc4_q, tc5_q;
  logic        [69:0]     tt4_q, q5_q;
  logic        [61:0]     rr4_q, rr5_q;
  pd_t                    pd6_q;
  sq_t                    sh6_q;

  always_ff @(posedge clk_i) begin
    logic [QT_W-1:0]      qv;
    logic signed [29:0]   ns;
    logic [31:0]          bm;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        qv = db_q[NQ_BITS-1][i].quo;
        ns = pb_q[NQ_BITS-1].dneg[i] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
        prod1_q[i]   <= $signed(pb_q[NQ_BITS-1].w[i]) * ns;
        pc1_q.nq[i]  <= qv;
        bm = 32'(qv >> BACK_SH);
        pc1_q.bk[i]  <= pb_q[NQ_BITS-1].dneg[i] ? bm : 32'(-bm);
      end
      pc1_q.o     <= pb_q[NQ_BITS-1].o;
      pc1_q.dneg  <= pb_q[NQ_BITS-1].dneg;
      pc1_q.sw    <= pb_q[NQ_BITS-1].sw;
      pc1_q.lzero <= pb_q[NQ_BITS-1].len == '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      proj2_q <= -(65'(prod1_q[0]) + 65'(prod1_q[1]) + 65'(prod1_q[2]));
      pc2_q   <= pc1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [64:0] am;
    logic [36:0] sm;
    if (en) begin
      am = proj2_q[64] ? 65'(-proj2_q) : 65'(proj2_q);
      sm = am[64:UNIT_BITS];
      tc3_q <= proj2_q[64] ? 36'(-sm) : 36'(sm);
      pc3_q <= pc2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [35:0] tm;
    if (en) begin
      tm = tc3_q[35] ? 36'(-tc3_q) : 36'(tc3_q);
      tt4_q <= 70'(tm[34:0]) * 70'(tm[34:0]);
      rr4_q <= 62'(rad_q) * 62'(rad_q);
      tc4_q <= tc3_q;
      pc4_q <= pc3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q5_q  <= (70'(pc4_q.sw) > tt4_q) ? 70'(pc4_q.sw) - tt4_q : '0;
      rr5_q <= rr4_q;
      tc5_q <= tc4_q;
      pc5_q <= pc4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic lt;
    if (en) begin
      lt = q5_q < 70'(rr5_q);
      pd6_q.pc <= pc5_q;
      pd6_q.tc <= tc5_q;
      pd6_q.lt <= lt;
      pd6_q.eq <= q5_q == 70'(rr5_q);
      sh6_q.rem  <= lt ? SQ_W'(rr5_q - q5_q[61:0]) : '0;
      sh6_q.root <= '0;
    end
  end

  // half chord
  sq_t sh_q [HALF_BITS];
  pd_t pd_q [HALF_BITS];

  for (genvar k = 0; k < HALF_BITS; k++) begin : g_sqrt_half
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en) begin
          sh_q[k] <= sqrt_step(sh6_q, HALF_BITS - 1 - k);
          pd_q[k] <= pd6_q;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en) begin
          sh_q[k] <= sqrt_step(sh_q[k-1], HALF_BITS - 1 - k);
          pd_q[k] <= pd_q[k-1];
        end
      end
    end
  end

  // root choice, hit point
  logic [34:0]      t1_q;
  logic             hit1_q, tang1_q, hit2_q, tang2_q;
  pc_t              pc6_q, pc7_q;
  logic [2:0][63:0] raw2_q;
  pe_t              pe3_q, pe4_q, pe5_q;
  logic [2:0][63:0] vsq5_q;
  pe_t              pe6_q;
  sq_t              sv6_q;

  always_ff @(posedge clk_i) begin
    logic [30:0]        h;
    logic signed [36:0] tce, tmh, tph;
    logic               tpos, mpos, ppos;
    if (en) begin
      h    = sh_q[HALF_BITS-1].root[HALF_BITS-1:0];
      tce  = 37'($signed(pd_q[HALF_BITS-1].tc));
      tmh  = tce - $signed({6'b0, h});
      tph  = tce + $signed({6'b0, h});
      tpos = !tce[36] && (tce != '0);
      mpos = !tmh[36] && (tmh != '0);
      ppos = !tph[36] && (tph != '0);
      hit1_q  <= !pd_q[HALF_BITS-1].pc.lzero
                 && ((pd_q[HALF_BITS-1].eq && tpos) || (pd_q[HALF_BITS-1].lt && (mpos || ppos)));
      tang1_q <= pd_q[HALF_BITS-1].eq;
      if (pd_q[HALF_BITS-1].eq) begin
        t1_q <= tce[34:0];
      end else if (mpos) begin
        t1_q <= tmh[34:0];
      end else begin
        t1_q <= tph[34:0];
      end
      pc6_q <= pd_q[HALF_BITS-1].pc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        raw2_q[i] <= 64'(t1_q) * 64'(pc6_q.nq[i]);
      end
      hit2_q  <= hit1_q;
      tang2_q <= tang1_q;
      pc7_q   <= pc6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [64:0]        rs;
    logic [37:0]        m;
    logic signed [37:0] off, ps;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rs  = 65'(raw2_q[i]) + 65'(1 << (UNIT_BITS - 1));
        m   = 38'(rs[64:UNIT_BITS]);
        off = pc7_q.dneg[i] ? -$signed(m) : $signed(m);
        ps  = $signed({{6{pc7_q.o[i][31]}}, pc7_q.o[i]}) + off;
        pe3_q.p[i] <= sat32(ps);
      end
      pe3_q.bk   <= pc7_q.bk;
      pe3_q.v    <= '0;
      pe3_q.hit  <= hit2_q;
      pe3_q.tang <= tang2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pe4_q.p    <= pe3_q.p;
      pe4_q.bk   <= pe3_q.bk;
      pe4_q.hit  <= pe3_q.hit;
      pe4_q.tang <= pe3_q.tang;
      for (int i = 0; i < 3; i++) begin
        pe4_q.v[i] <= 33'($signed({pe3_q.p[i][31], pe3_q.p[i]})
                      - $signed({ctr_q[i][31], ctr_q[i]}));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        vsq5_q[i] <= 64'(mag33(pe4_q.v[i])) * 64'(mag33(pe4_q.v[i]));
      end
      pe5_q <= pe4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sv6_q.rem  <= SQ_W'(66'(vsq5_q[0]) + 66'(vsq5_q[1]) + 66'(vsq5_q[2]));
      sv6_q.root <= '0;
      pe6_q      <= pe5_q;
    end
  end

  // length of point minus centre
  sq_t sv_q [LEN_BITS];
  pe_t pv_q [LEN_BITS];

  for (genvar k = 0; k < LEN_BITS; k++) begin : g_sqrt_nrm
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en) begin
          sv_q[k] <= sqrt_step(sv6_q, LEN_BITS - 1 - k);
          pv_q[k] <= pe6_q;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en) begin
          sv_q[k] <= sqrt_step(sv_q[k-1], LEN_BITS - 1 - k);
          pv_q[k] <= pv_q[k-1];
        end
      end
    end
  end

  // unit normal, three divide lanes
  dv_t dn_q [NRM_BITS][3];
  pf_t pf_q [NRM_BITS];
  pf_t pf_d;

  assign pf_d.pe = pv_q[LEN_BITS-1];
  assign pf_d.vl = sv_q[LEN_BITS-1].root[LEN_BITS-1:0];

  for (genvar k = 0; k < NRM_BITS; k++) begin : g_div_nrm
    for (genvar i = 0; i < 3; i++) begin : g_lane
      if (k == 0) begin : g_first
        always_ff @(posedge clk_i) begin
          if (en) begin
            dn_q[k][i] <= div_step('{rem: DV_W'(mag33(pf_d.pe.v[i])) << FRAC_BITS, quo: '0},
                                   pf_d.vl, NRM_BITS - 1 - k);
          end
        end
      end else begin : g_next
        always_ff @(posedge clk_i) begin
          if (en) begin
            dn_q[k][i] <= div_step(dn_q[k-1][i], pf_q[k-1].vl, NRM_BITS - 1 - k);
          end
        end
      end
    end
    if (k == 0) begin : g_pl_first
      always_ff @(posedge clk_i) begin
        if (en) begin
          pf_q[k] <= pf_d;
        end
      end
    end else begin : g_pl_next
      always_ff @(posedge clk_i) begin
        if (en) begin
          pf_q[k] <= pf_q[k-1];
        end
      end
    end
  end

  // output register, all zero on a miss
  logic [287:0] out_q;
  logic         hit_q;

  always_ff @(posedge clk_i) begin
    pf_t         f;
    logic [31:0] nm;
    if (en) begin
      f = pf_q[NRM_BITS-1];
      hit_q <= f.pe.hit;
      for (int i = 0; i < 3; i++) begin
        nm = 32'(dn_q[NRM_BITS-1][i].quo);
        if (!f.pe.hit) begin
          out_q[32*i +: 32]     <= '0;
          out_q[96+32*i +: 32]  <= '0;
          out_q[192+32*i +: 32] <= '0;
        end else begin
          out_q[32*i +: 32] <= f.pe.p[i];
          if (f.vl == '0) begin
            out_q[96+32*i +: 32] <= '0;
          end else begin
            out_q[96+32*i +: 32] <= f.pe.v[i][32] ? 32'(-nm) : nm;
          end
          out_q[192+32*i +: 32] <= f.pe.tang ? '0 : f.pe.bk[i];
        end
      end
    end
  end

  assign m_axis_tdata_o = out_q;
  assign m_axis_tuser_o = hit_q;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("miss with nonzero payload");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipe moved during stall");

  a_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> vld_q[DEPTH-1:1] == $past(vld_q[DEPTH-2:0]))
    else $error("request lost or duplicated in pipe");

  a_unit_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0]
    |-> ($signed(m_axis_tdata_o[127:96]) <= 32'sd65536
         && $signed(m_axis_tdata_o[127:96]) >= -32'sd65536))
    else $error("normal out of unit range");

endmodule
